>>> src/lfac_pkg.sv
// ----------------------------------------------------------------------------
// lfac_pkg
// Shared types and constants for the fully associative LRU cache.
// ----------------------------------------------------------------------------
package lfac_pkg;

    // Default geometry
    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths
    localparam int CFG_BITS   = 5;
    localparam int STAMP_BITS = 32;
    localparam int SLOT_BITS  = 4;
    localparam int USER_BITS  = 2;

    localparam logic [CFG_BITS-1:0] CAP_RESET = CFG_BITS'(16);

    // Flag positions in the result tuser
    localparam int USER_HIT     = 0;
    localparam int USER_EVICTED = 1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIT_SCAN,
        ST_HIT_READ,
        ST_DECIDE,
        ST_LRU_SCAN,
        ST_KEY_READ,
        ST_UPDATE,
        ST_DONE
    } lfac_state_t;

    // Write controls for the entry store
    typedef struct packed {
        logic en;    // write the stamp
        logic full;  // write key and value as well
    } store_wr_t;

endpackage

>>> src/lru_fully_assoc_cache.sv
// One item at a time: the next request is taken in the cycle after the result is loaded.
// The store is scanned one entry per cycle, once for the key and, on a replacement, again
// for the oldest stamp. A waiting result sits in the output register while the next
// item is taken. Reset (rst_n, async, active low) empties the cache, zeroes the access
// clock and sets the capacity to 16.
// ----------------------------------------------------------------------------
// lru_fully_assoc_cache
// Fully associative cache with timestamp LRU replacement under a sequencer.
// ----------------------------------------------------------------------------
module lru_fully_assoc_cache #(
    parameter int ENTRIES    = lfac_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lfac_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfac_pkg::VALUE_BITS_DEF,
    parameter int IN_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    parameter int OUT_W = ((VALUE_BITS + lfac_pkg::SLOT_BITS + KEY_BITS + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [IN_W-1:0]                  s_tdata,   // lookup_key, fill_value
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_W-1:0]                 m_tdata,   // result_value, slot_index, evicted_key
    output logic [lfac_pkg::USER_BITS-1:0]   m_tuser,   // hit, evicted
    // Capacity register write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lfac_pkg::CFG_BITS-1:0]    cfg_data   // capacity_in_use
);
    import lfac_pkg::*;

    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int CAP_W    = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
    localparam int CMP_BITS = (KEY_BITS > STAMP_BITS) ? KEY_BITS : STAMP_BITS;

    lfac_state_t              state_reg, state_next;
    logic [CNT_BITS-1:0]      fill_reg, fill_next;
    logic [STAMP_BITS-1:0]    clock_reg, clock_next;
    logic [CFG_BITS-1:0]      cap_reg;
    logic                     pend_v_reg, pend_v_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [VALUE_BITS-1:0]    val_reg, val_next;
    logic [CNT_BITS-1:0]      n_reg, n_next;
    logic [CNT_BITS-1:0]      scan_reg, scan_next;
    logic [IDX_BITS-1:0]      pend_idx_reg, pend_idx_next;
    logic [IDX_BITS-1:0]      slot_reg, slot_next;
    logic [STAMP_BITS-1:0]    best_reg, best_next;
    logic                     found_reg, found_next;
    logic                     evict_reg, evict_next;
    logic [VALUE_BITS-1:0]    res_val_reg, res_val_next;
    logic [KEY_BITS-1:0]      old_key_reg, old_key_next;
    logic [OUT_W-1:0]         m_tdata_reg, m_tdata_next;
    logic [USER_BITS-1:0]     m_tuser_reg, m_tuser_next;

    store_wr_t                wr;
    logic [IDX_BITS-1:0]      scan_addr;
    logic [KEY_BITS-1:0]      rd_key;
    logic [STAMP_BITS-1:0]    rd_stamp;
    logic [VALUE_BITS-1:0]    rd_value;

    logic                     in_beat;
    logic                     out_free;
    logic                     issue;
    logic                     last_pend;
    logic [CAP_W-1:0]         cap_ext;
    logic [CAP_W-1:0]         eff_cap;
    logic                     has_room;
    logic [CMP_BITS-1:0]      cmp_a, cmp_b;
    logic                     cmp_eq, cmp_lt;
    logic [IDX_BITS+SLOT_BITS-1:0] slot_ext;

    // Handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Scan bookkeeping
    assign issue     = (scan_reg < n_reg);
    assign last_pend = ((CNT_BITS'(pend_idx_reg) + CNT_BITS'(1)) == n_reg);

    // Effective capacity: zero acts as one, saturates at ENTRIES
    assign cap_ext = CAP_W'(cap_reg);
    always_comb
    begin
        if (cap_ext == '0)
            eff_cap = CAP_W'(1);
        else if (cap_ext > CAP_W'(ENTRIES))
            eff_cap = CAP_W'(ENTRIES);
        else
            eff_cap = cap_ext;
    end
    assign has_room = (CAP_W'(n_reg) < eff_cap);

    // Shared comparator: keys during the hit scan, stamps during the LRU scan
    always_comb
    begin
        if (state_reg == ST_LRU_SCAN)
        begin
            cmp_a = CMP_BITS'(rd_stamp);
            cmp_b = CMP_BITS'(best_reg);
        end
        else
        begin
            cmp_a = CMP_BITS'(rd_key);
            cmp_b = CMP_BITS'(key_reg);
        end
    end
    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_lt = (cmp_a < cmp_b);

    // Scan port follows the scan counter, or the chosen slot for the victim key
    assign scan_addr = (state_reg == ST_KEY_READ) ? slot_reg : scan_reg[IDX_BITS-1:0];

    lfac_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_store (
        .clk       (clk),
        .wr        (wr),
        .waddr     (slot_reg),
        .wkey      (key_reg),
        .wvalue    (val_reg),
        .wstamp    (clock_reg),
        .scan_addr (scan_addr),
        .val_addr  (slot_reg),
        .rd_key    (rd_key),
        .rd_stamp  (rd_stamp),
        .rd_value  (rd_value)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    state_next = (fill_reg == '0) ? ST_DECIDE : ST_HIT_SCAN;
            end
            ST_HIT_SCAN:
            begin
                if (pend_v_reg && cmp_eq)
                    state_next = ST_HIT_READ;
                else if (pend_v_reg && last_pend)
                    state_next = ST_DECIDE;
            end
            ST_HIT_READ: state_next = ST_UPDATE;
            ST_DECIDE:   state_next = has_room ? ST_UPDATE : ST_LRU_SCAN;
            ST_LRU_SCAN:
            begin
                if (pend_v_reg && last_pend)
                    state_next = ST_KEY_READ;
            end
            ST_KEY_READ: state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and store controls
    always_comb
    begin
        fill_next     = fill_reg;
        clock_next    = clock_reg;
        pend_v_next   = pend_v_reg;
        m_tvalid_next = m_tvalid_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        n_next        = n_reg;
        scan_next     = scan_reg;
        pend_idx_next = pend_idx_reg;
        slot_next     = slot_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        evict_next    = evict_reg;
        res_val_next  = res_val_reg;
        old_key_next  = old_key_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        wr            = '0;

        // Result leaves the output register
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    key_next    = s_tdata[KEY_BITS-1:0];
                    val_next    = s_tdata[KEY_BITS +: VALUE_BITS];
                    n_next      = fill_reg;
                    scan_next   = '0;
                    pend_v_next = 1'b0;
                    found_next  = 1'b0;
                    evict_next  = 1'b0;
                end
            end
            ST_HIT_SCAN, ST_LRU_SCAN:
            begin
                // issue the next read, compare the one read last cycle
                pend_v_next   = issue;
                pend_idx_next = scan_reg[IDX_BITS-1:0];
                if (issue)
                    scan_next = scan_reg + CNT_BITS'(1);
                if (pend_v_reg)
                begin
                    if (state_reg == ST_HIT_SCAN)
                    begin
                        if (cmp_eq)
                        begin
                            found_next  = 1'b1;
                            slot_next   = pend_idx_reg;
                            pend_v_next = 1'b0;
                        end
                    end
                    else if ((pend_idx_reg == '0) || cmp_lt)
                    begin
                        best_next = rd_stamp;
                        slot_next = pend_idx_reg;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (has_room)
                    slot_next = n_reg[IDX_BITS-1:0];
                else
                begin
                    evict_next  = 1'b1;
                    scan_next   = '0;
                    pend_v_next = 1'b0;
                end
            end
            ST_UPDATE:
            begin
                wr.en        = 1'b1;
                wr.full      = !found_reg;
                clock_next   = clock_reg + STAMP_BITS'(1);
                res_val_next = found_reg ? rd_value : val_reg;
                old_key_next = evict_reg ? rd_key : '0;
                if (!found_reg && !evict_reg)
                    fill_next = fill_reg + CNT_BITS'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({old_key_reg, slot_ext[SLOT_BITS-1:0], res_val_reg});
                    m_tuser_next  = '0;
                    m_tuser_next[USER_HIT]     = found_reg;
                    m_tuser_next[USER_EVICTED] = evict_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Slot number masked to the result field
    assign slot_ext = {{SLOT_BITS{1'b0}}, slot_reg};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            clock_reg    <= '0;
            cap_reg      <= CAP_RESET;
            pend_v_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            clock_reg    <= clock_next;
            pend_v_reg   <= pend_v_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        val_reg      <= val_next;
        n_reg        <= n_next;
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        evict_reg    <= evict_next;
        res_val_reg  <= res_val_next;
        old_key_reg  <= old_key_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // Fill count never passes the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_BITS'(ENTRIES))
        else $error("fill count beyond store depth");

    // A fill into a free slot bumps the fill count by one
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && !found_reg && !evict_reg)
        |=> fill_reg == $past(fill_reg) + CNT_BITS'(1))
        else $error("fill count did not advance on a fill");

    // The access clock advances once per item, at the store update
    a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> clock_reg == $past(clock_reg) + STAMP_BITS'(1))
        else $error("access clock did not advance");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_tuser_reg[USER_HIT] && m_tuser_reg[USER_EVICTED]))
        else $error("result flags both hit and eviction");

    // Scans stay within the filled slots
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HIT_SCAN || state_reg == ST_LRU_SCAN)
        |-> (scan_reg <= n_reg && n_reg <= CNT_BITS'(ENTRIES)))
        else $error("scan index beyond filled slots");
`endif

endmodule

>>> src/lfac_store.sv
// ----------------------------------------------------------------------------
// lfac_store
// Entry store: key, value and stamp memories, one write port, registered reads.
// ----------------------------------------------------------------------------
module lfac_store #(
    parameter int ENTRIES    = lfac_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lfac_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lfac_pkg::VALUE_BITS_DEF,
    parameter int IDX_BITS   = $clog2(ENTRIES)
) (
    input  logic                             clk,
    input  lfac_pkg::store_wr_t              wr,
    input  logic [IDX_BITS-1:0]              waddr,
    input  logic [KEY_BITS-1:0]              wkey,
    input  logic [VALUE_BITS-1:0]            wvalue,
    input  logic [lfac_pkg::STAMP_BITS-1:0]  wstamp,
    input  logic [IDX_BITS-1:0]              scan_addr,
    input  logic [IDX_BITS-1:0]              val_addr,
    output logic [KEY_BITS-1:0]              rd_key,
    output logic [lfac_pkg::STAMP_BITS-1:0]  rd_stamp,
    output logic [VALUE_BITS-1:0]            rd_value
);
    import lfac_pkg::*;

    logic [KEY_BITS-1:0]   keys_mem   [ENTRIES];
    logic [VALUE_BITS-1:0] vals_mem   [ENTRIES];
    logic [STAMP_BITS-1:0] stamps_mem [ENTRIES];

    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [STAMP_BITS-1:0] rd_stamp_reg;
    logic [VALUE_BITS-1:0] rd_value_reg;

    // Write port: stamp always, key and value on a fill or replacement
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            stamps_mem[waddr] <= wstamp;
            if (wr.full)
            begin
                keys_mem[waddr] <= wkey;
                vals_mem[waddr] <= wvalue;
            end
        end
    end

    // Registered reads (old data on a same-address write)
    always_ff @(posedge clk)
    begin
        rd_key_reg   <= keys_mem[scan_addr];
        rd_stamp_reg <= stamps_mem[scan_addr];
        rd_value_reg <= vals_mem[val_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_stamp = rd_stamp_reg;
    assign rd_value = rd_value_reg;

endmodule
